@@ src/qrs_pkg.sv @@
// shared types, widths and codes for the quadratic root solver
package qrs_pkg;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_DISTINCT   = 2'd0,
    KIND_EQUAL      = 2'd1,
    KIND_COMPLEX    = 2'd2,
    KIND_DEGENERATE = 2'd3
  } kind_t;

  localparam int CoefW  = 16;
  localparam int DiscW  = 34;
  localparam int NegbW  = 25;
  localparam int RadW   = 50;
  localparam int RootW  = 25;
  localparam int SremW  = 28;
  localparam int WordW  = 34;
  localparam int DremW  = 16;
  localparam int ValW   = 32;

  localparam int SqrtCells = RadW / 2;
  localparam int DivCells  = WordW;

  // sideband that travels with each beat down the cell rows
  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic signed [DiscW-1:0] disc;
    logic signed [NegbW-1:0] negb;
    logic                    a_neg;
    logic [CoefW-1:0]        a_mag;
    logic                    q1_neg;
    logic                    q2_neg;
  } side_t;

endpackage

@@ src/qrs_sqrt_cell.sv @@
// one cell of the square root row: settles one root bit per cycle while en is high
module qrs_sqrt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  qrs_pkg::side_t            side_in,
  input  logic [qrs_pkg::RadW-1:0]  rad_in,
  input  logic [qrs_pkg::SremW-1:0] rem_in,
  input  logic [qrs_pkg::RootW-1:0] root_in,
  output qrs_pkg::side_t            side_out,
  output logic [qrs_pkg::RadW-1:0]  rad_out,
  output logic [qrs_pkg::SremW-1:0] rem_out,
  output logic [qrs_pkg::RootW-1:0] root_out
);

  logic [qrs_pkg::SremW+1:0] rem_try;
  logic [qrs_pkg::SremW+1:0] trial;
  logic                      fits;
  logic [qrs_pkg::SremW+1:0] rem_diff;

  // trial subtract of (4*root + 1)
  always_comb begin
    rem_try  = {rem_in, rad_in[qrs_pkg::RadW-1 -: 2]};
    trial    = {3'b000, root_in, 2'b01};
    fits     = (rem_try >= trial);
    rem_diff = fits ? (rem_try - trial) : rem_try;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.kind   <= side_in.kind;
      side_out.disc   <= side_in.disc;
      side_out.negb   <= side_in.negb;
      side_out.a_neg  <= side_in.a_neg;
      side_out.a_mag  <= side_in.a_mag;
      side_out.q1_neg <= side_in.q1_neg;
      side_out.q2_neg <= side_in.q2_neg;
      rad_out  <= {rad_in[qrs_pkg::RadW-3:0], 2'b00};
      rem_out  <= rem_diff[qrs_pkg::SremW-1:0];
      root_out <= {root_in[qrs_pkg::RootW-2:0], fits};
    end
  end

endmodule

@@ src/qrs_div_cell.sv @@
// one cell of the divider row: one quotient bit per cycle for both roots while en is high
module qrs_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  qrs_pkg::side_t            side_in,
  input  logic [qrs_pkg::WordW-1:0] w1_in,
  input  logic [qrs_pkg::WordW-1:0] w2_in,
  input  logic [qrs_pkg::DremW-1:0] r1_in,
  input  logic [qrs_pkg::DremW-1:0] r2_in,
  output qrs_pkg::side_t            side_out,
  output logic [qrs_pkg::WordW-1:0] w1_out,
  output logic [qrs_pkg::WordW-1:0] w2_out,
  output logic [qrs_pkg::DremW-1:0] r1_out,
  output logic [qrs_pkg::DremW-1:0] r2_out
);

  logic [qrs_pkg::DremW:0] den;
  logic [qrs_pkg::DremW:0] t1;
  logic [qrs_pkg::DremW:0] t2;
  logic                    ge1;
  logic                    ge2;
  logic [qrs_pkg::DremW:0] d1;
  logic [qrs_pkg::DremW:0] d2;

  // restoring step on each lane
  always_comb begin
    den = {1'b0, side_in.a_mag};
    t1  = {r1_in, w1_in[qrs_pkg::WordW-1]};
    t2  = {r2_in, w2_in[qrs_pkg::WordW-1]};
    ge1 = (t1 >= den);
    ge2 = (t2 >= den);
    d1  = ge1 ? (t1 - den) : t1;
    d2  = ge2 ? (t2 - den) : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.kind   <= side_in.kind;
      side_out.disc   <= side_in.disc;
      side_out.negb   <= side_in.negb;
      side_out.a_neg  <= side_in.a_neg;
      side_out.a_mag  <= side_in.a_mag;
      side_out.q1_neg <= side_in.q1_neg;
      side_out.q2_neg <= side_in.q2_neg;
      w1_out <= {w1_in[qrs_pkg::WordW-2:0], ge1};
      w2_out <= {w2_in[qrs_pkg::WordW-2:0], ge2};
      r1_out <= d1[qrs_pkg::DremW-1:0];
      r2_out <= d2[qrs_pkg::DremW-1:0];
    end
  end

endmodule

@@ src/quadratic_root_solver.sv @@
// top level of the quadratic root solver: front math, cell rows, output stage
// Solves a*x^2 + b*x + c = 0 for signed Q8.8 coefficients and returns the
// root kind, two Q16.16 values (saturated, with overflow) and the exact
// discriminant. One coefficient set is accepted every cycle while in_stall is
// low; each passes through a multiply stage, a discriminant stage, a row
// of 25 square root cells (one root bit each), a numerator stage, a row of
// 34 divider cells (one quotient bit each) and a saturating output register.
// The whole pipe holds while a finished result waits with out_stall high.
module quadratic_root_solver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         coef_quad,
  input  logic signed [15:0]         coef_lin,
  input  logic signed [15:0]         coef_const,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 root_kind,
  output logic signed [31:0]         first_value,
  output logic signed [31:0]         second_value,
  output logic signed [33:0]         discriminant,
  output logic                       overflow
);

  localparam int NS = qrs_pkg::SqrtCells;
  localparam int ND = qrs_pkg::DivCells;

  logic en;

  // multiply stage
  logic                     m_valid;
  logic signed [31:0]       m_bb;
  logic signed [31:0]       m_ac;
  logic signed [15:0]       m_a;
  logic signed [15:0]       m_b;

  // discriminant stage outputs feeding the sqrt row
  qrs_pkg::side_t                s_side [0:NS];
  logic [qrs_pkg::RadW-1:0]      s_rad  [0:NS];
  logic [qrs_pkg::SremW-1:0]     s_rem  [0:NS];
  logic [qrs_pkg::RootW-1:0]     s_root [0:NS];

  // divider row
  qrs_pkg::side_t                d_side [0:ND];
  logic [qrs_pkg::WordW-1:0]     d_w1   [0:ND];
  logic [qrs_pkg::WordW-1:0]     d_w2   [0:ND];
  logic [qrs_pkg::DremW-1:0]     d_r1   [0:ND];
  logic [qrs_pkg::DremW-1:0]     d_r2   [0:ND];

  logic signed [33:0]  disc_c;
  logic [33:0]         disc_neg;
  logic signed [24:0]  negb_c;
  qrs_pkg::kind_t      kind_c;

  logic signed [26:0]  n1;
  logic signed [26:0]  n2;
  logic [26:0]         n1_mag;
  logic [26:0]         n2_mag;

  logic [31:0]         v1;
  logic [31:0]         v2;
  logic                sat1;
  logic                sat2;

  // pipe holds only while the output beat is stuck
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_bb <= coef_lin * coef_lin;
      m_ac <= coef_quad * coef_const;
      m_a  <= coef_quad;
      m_b  <= coef_lin;
    end
  end

  // discriminant, negated b and kind
  always_comb begin
    disc_c   = $signed({2'b00, m_bb}) - $signed({m_ac, 2'b00});
    disc_neg = -disc_c;
    negb_c   = -$signed({m_b[15], m_b, 8'h00});
    if (m_a == 16'sd0) begin
      kind_c = qrs_pkg::KIND_DEGENERATE;
    end else if (disc_c > 34'sd0) begin
      kind_c = qrs_pkg::KIND_DISTINCT;
    end else if (disc_c == 34'sd0) begin
      kind_c = qrs_pkg::KIND_EQUAL;
    end else begin
      kind_c = qrs_pkg::KIND_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_side[0].valid <= 1'b0;
    end else if (en) begin
      s_side[0].valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side[0].kind   <= kind_c;
      s_side[0].disc   <= disc_c;
      s_side[0].negb   <= negb_c;
      s_side[0].a_neg  <= m_a[15];
      s_side[0].a_mag  <= m_a[15] ? 16'(-m_a) : m_a;
      s_side[0].q1_neg <= 1'b0;
      s_side[0].q2_neg <= 1'b0;
      s_rad[0]  <= {1'b0, (disc_c[33] ? disc_neg[32:0] : disc_c[32:0]), 16'h0000};
      s_rem[0]  <= '0;
      s_root[0] <= '0;
    end
  end

  // square root row
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (s_side[i]),
      .rad_in   (s_rad[i]),
      .rem_in   (s_rem[i]),
      .root_in  (s_root[i]),
      .side_out (s_side[i+1]),
      .rad_out  (s_rad[i+1]),
      .rem_out  (s_rem[i+1]),
      .root_out (s_root[i+1])
    );
  end

  // numerators for both roots
  always_comb begin
    if (s_side[NS].disc > 34'sd0) begin
      n1 = 27'(s_side[NS].negb) + $signed({2'b00, s_root[NS]});
    end else begin
      n1 = 27'(s_side[NS].negb);
    end
    if (s_side[NS].disc < 34'sd0) begin
      n2 = $signed({2'b00, s_root[NS]});
    end else begin
      n2 = 27'(s_side[NS].negb) - $signed({2'b00, s_root[NS]});
    end
    n1_mag = n1[26] ? 27'(-n1) : n1;
    n2_mag = n2[26] ? 27'(-n2) : n2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_side[0].valid <= 1'b0;
    end else if (en) begin
      d_side[0].valid <= s_side[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side[0].kind   <= s_side[NS].kind;
      d_side[0].disc   <= s_side[NS].disc;
      d_side[0].negb   <= s_side[NS].negb;
      d_side[0].a_neg  <= s_side[NS].a_neg;
      d_side[0].a_mag  <= s_side[NS].a_mag;
      d_side[0].q1_neg <= n1[26] ^ s_side[NS].a_neg;
      d_side[0].q2_neg <= n2[26] ^ s_side[NS].a_neg;
      d_w1[0] <= {1'b0, n1_mag[25:0], 7'h00};
      d_w2[0] <= {1'b0, n2_mag[25:0], 7'h00};
      d_r1[0] <= '0;
      d_r2[0] <= '0;
    end
  end

  // divider row
  for (genvar j = 0; j < ND; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (d_side[j]),
      .w1_in    (d_w1[j]),
      .w2_in    (d_w2[j]),
      .r1_in    (d_r1[j]),
      .r2_in    (d_r2[j]),
      .side_out (d_side[j+1]),
      .w1_out   (d_w1[j+1]),
      .w2_out   (d_w2[j+1]),
      .r1_out   (d_r1[j+1]),
      .r2_out   (d_r2[j+1])
    );
  end

  // sign and saturation
  always_comb begin
    if (d_side[ND].q1_neg) begin
      sat1 = (d_w1[ND][33:32] != 2'b00) || (d_w1[ND][31] && (d_w1[ND][30:0] != 31'd0));
      v1   = sat1 ? 32'h8000_0000 : 32'(-d_w1[ND][31:0]);
    end else begin
      sat1 = (d_w1[ND][33:31] != 3'b000);
      v1   = sat1 ? 32'h7fff_ffff : d_w1[ND][31:0];
    end
    if (d_side[ND].q2_neg) begin
      sat2 = (d_w2[ND][33:32] != 2'b00) || (d_w2[ND][31] && (d_w2[ND][30:0] != 31'd0));
      v2   = sat2 ? 32'h8000_0000 : 32'(-d_w2[ND][31:0]);
    end else begin
      sat2 = (d_w2[ND][33:31] != 3'b000);
      v2   = sat2 ? 32'h7fff_ffff : d_w2[ND][31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_side[ND].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_kind    <= d_side[ND].kind;
      discriminant <= d_side[ND].disc;
      if (d_side[ND].kind == qrs_pkg::KIND_DEGENERATE) begin
        first_value  <= '0;
        second_value <= '0;
        overflow     <= 1'b0;
      end else begin
        first_value  <= v1;
        second_value <= v2;
        overflow     <= sat1 || sat2;
      end
    end
  end

  // degenerate beats carry zero roots and no overflow
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_kind == qrs_pkg::KIND_DEGENERATE) |->
      (first_value == 32'sd0 && second_value == 32'sd0 && !overflow))
    else $error("degenerate beat with nonzero roots");

  // a repeated root is reported twice
  a_equal_same: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_kind == qrs_pkg::KIND_EQUAL) |-> (first_value == second_value))
    else $error("equal roots differ");

  // overflow implies a clamped value
  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (first_value == 32'sh7fff_ffff || first_value == 32'sh8000_0000 ||
       second_value == 32'sh7fff_ffff || second_value == 32'sh8000_0000))
    else $error("overflow without saturated value");

  // complex kind implies a negative discriminant
  a_kind_disc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_kind == qrs_pkg::KIND_COMPLEX) |-> (discriminant < 34'sd0))
    else $error("complex kind with nonnegative discriminant");

endmodule
